@@ src/sqpn_pkg.sv @@
// ----------------------------------------------------------------------------
// sqpn_pkg
// shared widths, types, constant tables and arithmetic helpers for the
// superquadric point core
// ----------------------------------------------------------------------------
package sqpn_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;

  localparam int unsigned VEC_W     = 34;
  localparam int unsigned ANG_W     = 32;
  localparam int unsigned MAG_W     = 31;
  localparam int unsigned FRAC_W    = 30;
  localparam int unsigned REM_W     = 62;
  localparam int unsigned ROOT_BITS = 31;
  localparam int unsigned EXP_W     = 16;
  localparam int unsigned EXP_INT   = 4;
  localparam int unsigned EXP_FRAC  = 12;
  localparam int unsigned Q15_W     = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // four squaring stages, then per fraction bit a root chain and a multiply
  localparam int unsigned POW_LAT = EXP_INT + EXP_FRAC * (ROOT_BITS + 1);

  typedef logic signed [VEC_W-1:0] vec_t;
  typedef logic        [ANG_W-1:0] ang_t;
  typedef logic        [MAG_W-1:0] mag_t;
  typedef logic        [REM_W-1:0] rem_t;
  typedef logic        [EXP_W-1:0] exp_t;
  typedef logic signed [Q15_W-1:0] q15_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 1'b0,
    REG_BETA  = 1'b1
  } cfg_reg_e;

  localparam exp_t EXP_RESET = 16'd4096;
  localparam mag_t ONE_Q30   = 31'h4000_0000;
  localparam vec_t INV_GAIN  = 34'sd652032874;
  localparam vec_t QUARTER   = 34'sh0_4000_0000;
  localparam vec_t HALF      = 34'sh0_8000_0000;
  localparam ang_t PHI_QUART = 32'h4000_0000;
  localparam ang_t PHI_3QUART = 32'hC000_0000;
  localparam ang_t PHI_HALF  = 32'h8000_0000;

  localparam ang_t ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  function automatic mag_t mul_q30(mag_t a, mag_t b);
    logic [2*MAG_W-1:0] p;
    p = {{MAG_W{1'b0}}, a} * {{MAG_W{1'b0}}, b};
    return mag_t'(p >> FRAC_W);
  endfunction

  function automatic mag_t mag_clamp(vec_t v);
    logic [VEC_W-1:0] a;
    a = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
    if (a > VEC_W'(ONE_Q30)) begin
      return ONE_Q30;
    end
    return mag_t'(a);
  endfunction

  function automatic q15_t to_q15(logic neg, mag_t m);
    logic [MAG_W:0] sum;
    logic [16:0]    r;
    sum = {1'b0, m} + (MAG_W+1)'(16384);
    r   = 17'(sum >> 15);
    if (neg) begin
      if (r > 17'd32768) begin
        r = 17'd32768;
      end
      return q15_t'(17'd0 - r);
    end
    if (r > 17'd32767) begin
      r = 17'd32767;
    end
    return q15_t'(r);
  endfunction

endpackage

@@ src/sqpn_if.sv @@
// ----------------------------------------------------------------------------
// sqpn_in_if / sqpn_out_if
// valid/ready channels carrying a normal in and a surface point out
// ----------------------------------------------------------------------------
interface sqpn_in_if;
  logic               valid;
  logic               ready;
  sqpn_pkg::q15_t     normal_x;
  sqpn_pkg::q15_t     normal_y;
  sqpn_pkg::q15_t     normal_z;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  input ready);
  modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                  output ready);
endinterface

interface sqpn_out_if;
  logic               valid;
  logic               ready;
  sqpn_pkg::q15_t     pos_x;
  sqpn_pkg::q15_t     pos_y;
  sqpn_pkg::q15_t     pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  output ready);
endinterface

@@ src/sqpn_vec_cell.sv @@
// ----------------------------------------------------------------------------
// sqpn_vec_cell
// one vectoring cordic micro-rotation, registered
// ----------------------------------------------------------------------------
module sqpn_vec_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  sqpn_pkg::vec_t       x_i,
  input  sqpn_pkg::vec_t       y_i,
  input  sqpn_pkg::ang_t       acc_i,
  input  logic [SIDE_W-1:0]    side_i,
  output sqpn_pkg::vec_t       x_o,
  output sqpn_pkg::vec_t       y_o,
  output sqpn_pkg::ang_t       acc_o,
  output logic [SIDE_W-1:0]    side_o
);

  sqpn_pkg::vec_t x_d, y_d;
  sqpn_pkg::ang_t acc_d;

  always_comb begin
    if (y_i > 0) begin
      x_d   = x_i + (y_i >>> IDX);
      y_d   = y_i - (x_i >>> IDX);
      acc_d = acc_i + sqpn_pkg::ATAN_TURNS[IDX];
    end else begin
      x_d   = x_i - (y_i >>> IDX);
      y_d   = y_i + (x_i >>> IDX);
      acc_d = acc_i - sqpn_pkg::ATAN_TURNS[IDX];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o    <= x_d;
      y_o    <= y_d;
      acc_o  <= acc_d;
      side_o <= side_i;
    end
  end

endmodule

@@ src/sqpn_rot_cell.sv @@
// ----------------------------------------------------------------------------
// sqpn_rot_cell
// one rotation cordic micro-rotation, registered
// ----------------------------------------------------------------------------
module sqpn_rot_cell #(
  parameter int unsigned IDX    = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  sqpn_pkg::vec_t       c_i,
  input  sqpn_pkg::vec_t       s_i,
  input  sqpn_pkg::vec_t       res_i,
  input  logic [SIDE_W-1:0]    side_i,
  output sqpn_pkg::vec_t       c_o,
  output sqpn_pkg::vec_t       s_o,
  output sqpn_pkg::vec_t       res_o,
  output logic [SIDE_W-1:0]    side_o
);

  sqpn_pkg::vec_t c_d, s_d, res_d, step;

  always_comb begin
    step = sqpn_pkg::vec_t'(sqpn_pkg::ATAN_TURNS[IDX]);
    if (res_i >= 0) begin
      c_d   = c_i - (s_i >>> IDX);
      s_d   = s_i + (c_i >>> IDX);
      res_d = res_i - step;
    end else begin
      c_d   = c_i + (s_i >>> IDX);
      s_d   = s_i - (c_i >>> IDX);
      res_d = res_i + step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_o    <= c_d;
      s_o    <= s_d;
      res_o  <= res_d;
      side_o <= side_i;
    end
  end

endmodule

@@ src/sqpn_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// sqpn_sqrt_cell
// one result bit of a restoring integer square root, registered
// ----------------------------------------------------------------------------
module sqpn_sqrt_cell #(
  parameter int unsigned BIT    = 0,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  sqpn_pkg::rem_t       rem_i,
  input  sqpn_pkg::mag_t       q_i,
  input  logic [SIDE_W-1:0]    side_i,
  output sqpn_pkg::rem_t       rem_o,
  output sqpn_pkg::mag_t       q_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int unsigned TW = sqpn_pkg::REM_W + 2;

  logic [TW-1:0]  trial;
  sqpn_pkg::rem_t rem_d;
  sqpn_pkg::mag_t q_d;

  always_comb begin
    trial = (TW'(q_i) << (BIT + 1)) + (TW'(1) << (2 * BIT));
    rem_d = rem_i;
    q_d   = q_i;
    if ({2'b00, rem_i} >= trial) begin
      rem_d = rem_i - sqpn_pkg::rem_t'(trial);
      q_d   = q_i | (sqpn_pkg::mag_t'(1) << BIT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= rem_d;
      q_o    <= q_d;
      side_o <= side_i;
    end
  end

endmodule

@@ src/sqpn_pow.sv @@
// ----------------------------------------------------------------------------
// sqpn_pow
// pipelined |t|^e for a q1.30 magnitude and a q4.12 exponent: squarings for
// the integer bits, chained square roots for the fraction bits
// ----------------------------------------------------------------------------
module sqpn_pow (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  sqpn_pkg::mag_t       m_i,
  input  sqpn_pkg::exp_t       exp_i,
  output sqpn_pkg::mag_t       p_o
);

  localparam int unsigned NI = sqpn_pkg::EXP_INT;
  localparam int unsigned NF = sqpn_pkg::EXP_FRAC;
  localparam int unsigned NB = sqpn_pkg::ROOT_BITS;
  localparam int unsigned AW = sqpn_pkg::MAG_W;

  sqpn_pkg::mag_t iacc_q  [NI];
  sqpn_pkg::mag_t ibase_q [NI];
  sqpn_pkg::mag_t iroot_q [NI];
  sqpn_pkg::mag_t facc_q  [NF];
  sqpn_pkg::mag_t froot_q [NF];

  for (genvar k = 0; k < NI; k++) begin : g_int
    sqpn_pkg::mag_t acc_p, base_p, root_p;
    if (k == 0) begin : g_first
      assign acc_p  = sqpn_pkg::ONE_Q30;
      assign base_p = m_i;
      assign root_p = m_i;
    end else begin : g_next
      assign acc_p  = iacc_q[k-1];
      assign base_p = ibase_q[k-1];
      assign root_p = iroot_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        iacc_q[k]  <= exp_i[NF+k] ? sqpn_pkg::mul_q30(acc_p, base_p) : acc_p;
        ibase_q[k] <= sqpn_pkg::mul_q30(base_p, base_p);
        iroot_q[k] <= root_p;
      end
    end
  end

  for (genvar j = 0; j < NF; j++) begin : g_frac
    sqpn_pkg::rem_t rem_w [NB+1];
    sqpn_pkg::mag_t q_w   [NB+1];
    logic [AW-1:0]  acc_w [NB+1];
    sqpn_pkg::mag_t acc_p, root_p;

    if (j == 0) begin : g_first
      assign acc_p  = iacc_q[NI-1];
      assign root_p = iroot_q[NI-1];
    end else begin : g_next
      assign acc_p  = facc_q[j-1];
      assign root_p = froot_q[j-1];
    end

    assign rem_w[0] = sqpn_pkg::rem_t'(root_p) << sqpn_pkg::FRAC_W;
    assign q_w[0]   = '0;
    assign acc_w[0] = acc_p;

    for (genvar b = 0; b < NB; b++) begin : g_cell
      sqpn_sqrt_cell #(
        .BIT    (NB - 1 - b),
        .SIDE_W (AW)
      ) u_cell (
        .clk_i  (clk_i),
        .en_i   (en_i),
        .rem_i  (rem_w[b]),
        .q_i    (q_w[b]),
        .side_i (acc_w[b]),
        .rem_o  (rem_w[b+1]),
        .q_o    (q_w[b+1]),
        .side_o (acc_w[b+1])
      );
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        facc_q[j]  <= exp_i[NF-1-j] ? sqpn_pkg::mul_q30(acc_w[NB], q_w[NB]) : acc_w[NB];
        froot_q[j] <= q_w[NB];
      end
    end
  end

  assign p_o = facc_q[NF-1];

endmodule

@@ src/superquadric_point_from_normal_core.sv @@
// ----------------------------------------------------------------------------
// superquadric_point_from_normal_core
// maps a unit normal to the superquadric surface point with the same polar
// angles, using cordic chains, root chains and pipelined power units
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_i      in   valid / ready        normal_x, normal_y, normal_z (q1.15)
//  out_o     out  valid / ready        pos_x, pos_y, pos_z (q1.15)
//  cfg       in   cfg_we_i, no stall   cfg_idx_i, cfg_data_i (q4.12 exponents)
//
//  one transaction per cycle while the output is not held; the path runs through
//  the two cordic chains, the sine root chain and twelve root chains per power
//  all stages advance together; a held output stalls the whole pipeline and
//  in_i.ready drops with it, bubbles stay in place while the output waits
//  reset clears the valid line and sets both exponents to 1.0
// ----------------------------------------------------------------------------
module superquadric_point_from_normal_core #(
  parameter int unsigned CORDIC_STAGES = sqpn_pkg::CORDIC_STAGES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  sqpn_in_if.sink                            in_i,
  sqpn_out_if.source                         out_o,
  input  logic                               cfg_we_i,
  input  logic [sqpn_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [sqpn_pkg::EXP_W-1:0]         cfg_data_i
);

  localparam int unsigned N   = CORDIC_STAGES;
  localparam int unsigned NB  = sqpn_pkg::ROOT_BITS;
  localparam int unsigned PL  = sqpn_pkg::POW_LAT;
  localparam int unsigned LAT = 2 * N + 6 + NB + PL;
  localparam int unsigned ZW  = sqpn_pkg::Q15_W;
  localparam int unsigned VW  = sqpn_pkg::VEC_W;
  localparam int unsigned VSW = ZW + 2;
  localparam int unsigned QSW = 2 * VW + ZW;

  // configuration
  sqpn_pkg::exp_t alpha_q, beta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= sqpn_pkg::EXP_RESET;
      beta_q  <= sqpn_pkg::EXP_RESET;
    end else if (cfg_we_i) begin
      case (sqpn_pkg::cfg_reg_e'(cfg_idx_i))
        sqpn_pkg::REG_ALPHA: alpha_q <= cfg_data_i;
        sqpn_pkg::REG_BETA:  beta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline control
  logic           en;
  logic [LAT-1:0] vld_q;

  assign en         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  // input stage: prescale and half-turn pre-rotation
  sqpn_pkg::vec_t  s0_x_q, s0_y_q, s0_x_d, s0_y_d;
  sqpn_pkg::ang_t  s0_acc_q;
  logic [VSW-1:0]  s0_side_q;
  sqpn_pkg::vec_t  xs, ys;

  always_comb begin
    xs = sqpn_pkg::vec_t'(in_i.normal_x) <<< 14;
    ys = sqpn_pkg::vec_t'(in_i.normal_y) <<< 14;
    s0_x_d = in_i.normal_x[ZW-1] ? -xs : xs;
    s0_y_d = in_i.normal_x[ZW-1] ? -ys : ys;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_x_q    <= s0_x_d;
      s0_y_q    <= s0_y_d;
      s0_acc_q  <= in_i.normal_x[ZW-1] ? sqpn_pkg::PHI_HALF : '0;
      s0_side_q <= {in_i.normal_z, (in_i.normal_x == '0), (in_i.normal_y > 0)};
    end
  end

  // vectoring chain
  sqpn_pkg::vec_t vx_w   [N+1];
  sqpn_pkg::vec_t vy_w   [N+1];
  sqpn_pkg::ang_t vacc_w [N+1];
  logic [VSW-1:0] vside_w [N+1];

  assign vx_w[0]    = s0_x_q;
  assign vy_w[0]    = s0_y_q;
  assign vacc_w[0]  = s0_acc_q;
  assign vside_w[0] = s0_side_q;

  for (genvar i = 0; i < N; i++) begin : g_vec
    sqpn_vec_cell #(.IDX(i), .SIDE_W(VSW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .x_i    (vx_w[i]),
      .y_i    (vy_w[i]),
      .acc_i  (vacc_w[i]),
      .side_i (vside_w[i]),
      .x_o    (vx_w[i+1]),
      .y_o    (vy_w[i+1]),
      .acc_o  (vacc_w[i+1]),
      .side_o (vside_w[i+1])
    );
  end

  // azimuth fold into one half turn
  sqpn_pkg::ang_t phi;
  sqpn_pkg::vec_t res, f_res_q, f_c_q;
  logic [ZW-1:0]  f_z_q;
  logic           f_flip;

  always_comb begin
    if (vside_w[N][1]) begin
      phi = vside_w[N][0] ? sqpn_pkg::PHI_QUART : sqpn_pkg::PHI_3QUART;
    end else begin
      phi = vacc_w[N];
    end
    res    = sqpn_pkg::vec_t'($signed(phi));
    f_flip = 1'b0;
    if (res > sqpn_pkg::QUARTER) begin
      res    = res - sqpn_pkg::HALF;
      f_flip = 1'b1;
    end else if (res < -sqpn_pkg::QUARTER) begin
      res    = res + sqpn_pkg::HALF;
      f_flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_res_q <= res;
      f_c_q   <= f_flip ? -sqpn_pkg::INV_GAIN : sqpn_pkg::INV_GAIN;
      f_z_q   <= vside_w[N][VSW-1:2];
    end
  end

  // rotation chain
  sqpn_pkg::vec_t rc_w   [N+1];
  sqpn_pkg::vec_t rs_w   [N+1];
  sqpn_pkg::vec_t rres_w [N+1];
  logic [ZW-1:0]  rz_w   [N+1];

  assign rc_w[0]   = f_c_q;
  assign rs_w[0]   = '0;
  assign rres_w[0] = f_res_q;
  assign rz_w[0]   = f_z_q;

  for (genvar i = 0; i < N; i++) begin : g_rot
    sqpn_rot_cell #(.IDX(i), .SIDE_W(ZW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .c_i    (rc_w[i]),
      .s_i    (rs_w[i]),
      .res_i  (rres_w[i]),
      .side_i (rz_w[i]),
      .c_o    (rc_w[i+1]),
      .s_o    (rs_w[i+1]),
      .res_o  (rres_w[i+1]),
      .side_o (rz_w[i+1])
    );
  end

  // sine of the polar angle: 1 - z^2 into the root chain
  logic signed [31:0] zz;
  sqpn_pkg::rem_t     m_rem_q;
  logic [QSW-1:0]     m_side_q;

  assign zz = 32'($signed(rz_w[N])) * 32'($signed(rz_w[N]));

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_rem_q  <= sqpn_pkg::rem_t'(sqpn_pkg::mag_t'(32'sh4000_0000 - zz))
                  << sqpn_pkg::FRAC_W;
      m_side_q <= {rc_w[N], rs_w[N], rz_w[N]};
    end
  end

  sqpn_pkg::rem_t qrem_w  [NB+1];
  sqpn_pkg::mag_t qq_w    [NB+1];
  logic [QSW-1:0] qside_w [NB+1];

  assign qrem_w[0]  = m_rem_q;
  assign qq_w[0]    = '0;
  assign qside_w[0] = m_side_q;

  for (genvar b = 0; b < NB; b++) begin : g_sqrt
    sqpn_sqrt_cell #(.BIT(NB - 1 - b), .SIDE_W(QSW)) u_cell (
      .clk_i  (clk_i),
      .en_i   (en),
      .rem_i  (qrem_w[b]),
      .q_i    (qq_w[b]),
      .side_i (qside_w[b]),
      .rem_o  (qrem_w[b+1]),
      .q_o    (qq_w[b+1]),
      .side_o (qside_w[b+1])
    );
  end

  // power bases and signs
  sqpn_pkg::vec_t bc, bs, bz;
  sqpn_pkg::mag_t b_st_q, b_c_q, b_s_q, b_z_q;
  logic [2:0]     b_sgn_q;

  assign bc = qside_w[NB][QSW-1 -: VW];
  assign bs = qside_w[NB][ZW +: VW];
  assign bz = sqpn_pkg::vec_t'($signed(qside_w[NB][ZW-1:0])) <<< 15;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_st_q  <= (qq_w[NB] > sqpn_pkg::ONE_Q30) ? sqpn_pkg::ONE_Q30 : qq_w[NB];
      b_c_q   <= sqpn_pkg::mag_clamp(bc);
      b_s_q   <= sqpn_pkg::mag_clamp(bs);
      b_z_q   <= sqpn_pkg::mag_clamp(bz);
      b_sgn_q <= {bc[VW-1], bs[VW-1], bz[VW-1]};
    end
  end

  sqpn_pkg::mag_t p_st, p_c, p_s, p_z;

  sqpn_pow u_pow_st (.clk_i(clk_i), .en_i(en), .m_i(b_st_q), .exp_i(alpha_q), .p_o(p_st));
  sqpn_pow u_pow_c  (.clk_i(clk_i), .en_i(en), .m_i(b_c_q),  .exp_i(beta_q),  .p_o(p_c));
  sqpn_pow u_pow_s  (.clk_i(clk_i), .en_i(en), .m_i(b_s_q),  .exp_i(beta_q),  .p_o(p_s));
  sqpn_pow u_pow_z  (.clk_i(clk_i), .en_i(en), .m_i(b_z_q),  .exp_i(beta_q),  .p_o(p_z));

  logic [2:0] sgn_q [PL];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sgn_q[0] <= b_sgn_q;
      for (int unsigned k = 1; k < PL; k++) begin
        sgn_q[k] <= sgn_q[k-1];
      end
    end
  end

  // products and output register
  sqpn_pkg::mag_t fx_q, fy_q, fz_q;
  logic [2:0]     fsgn_q;
  sqpn_pkg::q15_t ox_q, oy_q, oz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      fx_q   <= sqpn_pkg::mul_q30(p_st, p_c);
      fy_q   <= sqpn_pkg::mul_q30(p_st, p_s);
      fz_q   <= p_z;
      fsgn_q <= sgn_q[PL-1];
      ox_q   <= sqpn_pkg::to_q15(fsgn_q[2], fx_q);
      oy_q   <= sqpn_pkg::to_q15(fsgn_q[1], fy_q);
      oz_q   <= sqpn_pkg::to_q15(fsgn_q[0], fz_q);
    end
  end

  assign out_o.valid = vld_q[LAT-1];
  assign out_o.pos_x = ox_q;
  assign out_o.pos_y = oy_q;
  assign out_o.pos_z = oz_q;

endmodule
